@@ sv/fpgrc_pkg.sv @@
// fpgrc_pkg: shared types and codes for the force pad gesture relay controller.
// No dependencies; imported by every module of the block.
`default_nettype none

package fpgrc_pkg;

    localparam int NUM_PADS   = 4;
    localparam int ALPHA_BITS = 9;
    localparam int DEB_BITS   = 16;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_FILTER_ALPHA = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_THR_TL       = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_THR_TR       = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_THR_BL       = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_THR_BR       = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_DEBOUNCE     = 3'd5;

    // Reset values
    localparam logic [ALPHA_BITS-1:0] ALPHA_RESET    = 9'd26;
    localparam logic [ALPHA_BITS-1:0] ALPHA_ONE      = 9'd256;
    localparam logic [7:0]            THR_RESET      = 8'd200;
    localparam logic [DEB_BITS-1:0]   DEBOUNCE_RESET = 16'd50;

    // Activity patterns, bit0 TL, bit1 TR, bit2 BL, bit3 BR
    localparam logic [NUM_PADS-1:0] PAT_LOWER = 4'b0011;
    localparam logic [NUM_PADS-1:0] PAT_RAISE = 4'b1100;

    typedef enum logic
    {
        OP_CALIBRATE = 1'b0,
        OP_FRAME     = 1'b1
    } op_t;

    typedef struct packed
    {
        logic raise_on;
        logic lower_on;
        logic moving;
    } gest_stat_t;

endpackage : fpgrc_pkg

`default_nettype wire

@@ sv/force_pad_gesture_relay_control.sv @@
// Force pad gesture relay controller, top level.
// Data path: an accepted input word is loaded into the input register, then moved
//   on into the result register, where it is held as the valid result;
//   throughput one word per cycle, set by the single compute pass between the
//   two registers. Stalls only on m_tready low.
// Reset (rst_n, async low): pad stores, timers, relays cleared to zero;
//   config regs to alpha 26, thresholds 200, debounce 50. Depends on fpgrc_pkg.
`default_nettype none

module force_pad_gesture_relay_control #(
    parameter int SAMPLE_BITS = 12,
    parameter int TICK_BITS   = 32
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,

    // Input stream
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // tdata, low bit up: sample_top_left, sample_top_right, sample_bottom_left,
    // sample_bottom_right, present_mask, now_tick, zero pad
    input  wire logic [((4*SAMPLE_BITS+4+TICK_BITS+7)/8)*8-1:0] s_tdata,
    // tuser: op (0 calibrate, 1 frame)
    input  wire logic                                s_tuser,

    // Result stream
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // tdata, low bit up: raise_relay, lower_relay, motion_seen, pads_active[3:0],
    // filtered_top_left, filtered_top_right, filtered_bottom_left,
    // filtered_bottom_right, zero pad
    output logic      [((4*SAMPLE_BITS+7+7)/8)*8-1:0] m_tdata,

    // Configuration write channel
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [fpgrc_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [fpgrc_pkg::CFG_DATA_BITS-1:0] cfg_data
);
    import fpgrc_pkg::*;

    localparam int OUT_B  = 4*SAMPLE_BITS + 7;
    localparam int OUT_W  = ((OUT_B + 7) / 8) * 8;
    localparam int MASK_LO = 4*SAMPLE_BITS;
    localparam int NOW_LO  = 4*SAMPLE_BITS + 4;

    // ---------------- input register ----------------
    logic                   in_valid_reg;
    op_t                    in_op_reg;
    logic [SAMPLE_BITS-1:0] in_samp_reg [NUM_PADS];
    logic [NUM_PADS-1:0]    in_mask_reg;
    logic [TICK_BITS-1:0]   in_now_reg;

    logic                   out_valid_reg;
    logic [OUT_W-1:0]       out_data_reg, out_data_next;

    // advance: the word in the input register moves into the result register
    logic advance;
    logic step;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign step     = advance;
    assign s_tready = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_op_reg <= op_t'(s_tuser);
            for (int i = 0; i < NUM_PADS; i++)
                in_samp_reg[i] <= s_tdata[i*SAMPLE_BITS +: SAMPLE_BITS];
            in_mask_reg <= s_tdata[MASK_LO +: NUM_PADS];
            in_now_reg  <= s_tdata[NOW_LO +: TICK_BITS];
        end
    end

    // ---------------- configuration ----------------
    logic [ALPHA_BITS-1:0]  alpha;
    logic [SAMPLE_BITS-1:0] threshold [NUM_PADS];
    logic [DEB_BITS-1:0]    debounce;

    fpgrc_cfg_regs #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .alpha     (alpha),
        .threshold (threshold),
        .debounce  (debounce)
    );

    // ---------------- four pad channels ----------------
    // Each channel updates raw/filtered/baseline and compares in one pass;
    // the stores are written at the same edge the result is registered.
    logic [NUM_PADS-1:0]    act;
    logic [SAMPLE_BITS-1:0] filtered [NUM_PADS];
    logic                   any_present;

    assign any_present = |in_mask_reg;

    for (genvar g = 0; g < NUM_PADS; g++)
    begin : g_pad
        fpgrc_pad #(
            .SAMPLE_BITS (SAMPLE_BITS)
        ) u_pad (
            .clk         (clk),
            .rst_n       (rst_n),
            .step        (step),
            .op          (in_op_reg),
            .present     (in_mask_reg[g]),
            .any_present (any_present),
            .sample      (in_samp_reg[g]),
            .alpha       (alpha),
            .threshold   (threshold[g]),
            .active      (act[g]),
            .filtered    (filtered[g])
        );
    end

    // ---------------- gesture / debounce ----------------
    gest_stat_t stat;

    fpgrc_gesture #(
        .TICK_BITS (TICK_BITS)
    ) u_gesture (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .op       (in_op_reg),
        .act      (act),
        .now_tick (in_now_reg),
        .debounce (debounce),
        .stat     (stat)
    );

    // ---------------- result register ----------------
    always_comb
    begin
        out_data_next = OUT_W'({filtered[3], filtered[2], filtered[1], filtered[0],
                                act, stat.moving, stat.lower_on, stat.raise_on});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (!out_valid_reg || m_tready)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule : force_pad_gesture_relay_control

`default_nettype wire

@@ sv/fpgrc_cfg_regs.sv @@
// fpgrc_cfg_regs: configuration register file (alpha, four thresholds, debounce).
// Depends on fpgrc_pkg.
`default_nettype none

module fpgrc_cfg_regs #(
    parameter int SAMPLE_BITS = 12
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_we,
    input  wire logic [fpgrc_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  wire logic [fpgrc_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    output logic      [fpgrc_pkg::ALPHA_BITS-1:0]      alpha,
    output logic      [SAMPLE_BITS-1:0]                threshold [fpgrc_pkg::NUM_PADS],
    output logic      [fpgrc_pkg::DEB_BITS-1:0]        debounce
);
    import fpgrc_pkg::*;

    logic [ALPHA_BITS-1:0]  alpha_reg;
    logic [SAMPLE_BITS-1:0] thr_reg [NUM_PADS];
    logic [DEB_BITS-1:0]    deb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg <= ALPHA_RESET;
            for (int i = 0; i < NUM_PADS; i++)
                thr_reg[i] <= SAMPLE_BITS'(THR_RESET);
            deb_reg <= DEBOUNCE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FILTER_ALPHA: alpha_reg  <= cfg_data[ALPHA_BITS-1:0];
                REG_THR_TL:       thr_reg[0] <= cfg_data[SAMPLE_BITS-1:0];
                REG_THR_TR:       thr_reg[1] <= cfg_data[SAMPLE_BITS-1:0];
                REG_THR_BL:       thr_reg[2] <= cfg_data[SAMPLE_BITS-1:0];
                REG_THR_BR:       thr_reg[3] <= cfg_data[SAMPLE_BITS-1:0];
                REG_DEBOUNCE:     deb_reg    <= cfg_data[DEB_BITS-1:0];
                default:          ;
            endcase
        end
    end

    assign alpha     = alpha_reg;
    assign threshold = thr_reg;
    assign debounce  = deb_reg;

endmodule : fpgrc_cfg_regs

`default_nettype wire

@@ sv/fpgrc_pad.sv @@
// fpgrc_pad: one pad channel - raw/filtered/baseline store, Q1.8 filter step,
// and threshold compare. Depends on fpgrc_pkg.
`default_nettype none

module fpgrc_pad #(
    parameter int SAMPLE_BITS = 12
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              step,
    input  wire fpgrc_pkg::op_t                    op,
    input  wire logic                              present,
    input  wire logic                              any_present,
    input  wire logic [SAMPLE_BITS-1:0]            sample,
    input  wire logic [fpgrc_pkg::ALPHA_BITS-1:0]  alpha,
    input  wire logic [SAMPLE_BITS-1:0]            threshold,
    output logic                                   active,
    output logic      [SAMPLE_BITS-1:0]            filtered
);
    import fpgrc_pkg::*;

    localparam int PW = SAMPLE_BITS + ALPHA_BITS;

    logic [SAMPLE_BITS-1:0] raw_reg, raw_next;
    logic [SAMPLE_BITS-1:0] filt_reg, filt_next;
    logic [SAMPLE_BITS-1:0] base_reg, base_next;
    logic [ALPHA_BITS-1:0]  alpha_sat;
    logic                   up;
    logic [SAMPLE_BITS-1:0] diff;
    logic [PW-1:0]          prod;
    logic [SAMPLE_BITS-1:0] delta;
    logic [SAMPLE_BITS-1:0] filt_moved;

    // Filter step toward raw, truncated toward zero
    always_comb
    begin
        raw_next   = present ? sample : raw_reg;
        alpha_sat  = alpha[ALPHA_BITS-1] ? ALPHA_ONE : alpha;
        up         = raw_next >= filt_reg;
        diff       = up ? (raw_next - filt_reg) : (filt_reg - raw_next);
        prod       = PW'(diff) * PW'(alpha_sat);
        delta      = prod[SAMPLE_BITS+7:8];
        filt_moved = up ? (filt_reg + delta) : (filt_reg - delta);
    end

    always_comb
    begin
        case (op)
            OP_CALIBRATE:
            begin
                filt_next = raw_next;
                base_next = raw_next;
            end
            OP_FRAME:
            begin
                filt_next = any_present ? filt_moved : filt_reg;
                base_next = base_reg;
            end
            default:
            begin
                filt_next = filt_reg;
                base_next = base_reg;
            end
        endcase
    end

    // baseline - filtered >= threshold, done without a signed subtract
    assign active   = {1'b0, base_next} >= ({1'b0, filt_next} + {1'b0, threshold});
    assign filtered = filt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_reg  <= '0;
            filt_reg <= '0;
            base_reg <= '0;
        end
        else if (step)
        begin
            raw_reg  <= raw_next;
            filt_reg <= filt_next;
            base_reg <= base_next;
        end
    end

endmodule : fpgrc_pad

`default_nettype wire

@@ sv/fpgrc_gesture.sv @@
// fpgrc_gesture: raise/lower pattern detect, debounce timers and relay state.
// Depends on fpgrc_pkg.
`default_nettype none

module fpgrc_gesture #(
    parameter int TICK_BITS = 32
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                step,
    input  wire fpgrc_pkg::op_t                      op,
    input  wire logic [fpgrc_pkg::NUM_PADS-1:0]      act,
    input  wire logic [TICK_BITS-1:0]                now_tick,
    input  wire logic [fpgrc_pkg::DEB_BITS-1:0]      debounce,
    output fpgrc_pkg::gest_stat_t                    stat
);
    import fpgrc_pkg::*;

    logic                 lower_armed_reg, lower_armed_next;
    logic                 raise_armed_reg, raise_armed_next;
    logic                 lower_on_reg, lower_on_next;
    logic                 raise_on_reg, raise_on_next;
    logic [TICK_BITS-1:0] lower_start_reg, lower_start_next;
    logic [TICK_BITS-1:0] raise_start_reg, raise_start_next;
    logic                 lower_pat, raise_pat;
    logic [TICK_BITS-1:0] lower_elapsed, raise_elapsed;
    logic                 is_frame;

    always_comb
    begin
        is_frame      = (op == OP_FRAME);
        lower_pat     = (act == PAT_LOWER);
        raise_pat     = (act == PAT_RAISE);
        lower_elapsed = now_tick - lower_start_reg;
        raise_elapsed = now_tick - raise_start_reg;

        lower_armed_next = lower_armed_reg;
        raise_armed_next = raise_armed_reg;
        lower_on_next    = lower_on_reg;
        raise_on_next    = raise_on_reg;
        lower_start_next = lower_start_reg;
        raise_start_next = raise_start_reg;

        if (is_frame)
        begin
            if (lower_pat)
            begin
                if (!lower_armed_reg)
                begin
                    lower_armed_next = 1'b1;
                    lower_start_next = now_tick;
                end
                else if (lower_elapsed >= TICK_BITS'(debounce))
                    lower_on_next = 1'b1;
            end
            else if (raise_pat)
            begin
                if (!raise_armed_reg)
                begin
                    raise_armed_next = 1'b1;
                    raise_start_next = now_tick;
                end
                else if (raise_elapsed >= TICK_BITS'(debounce))
                    raise_on_next = 1'b1;
            end
            else
            begin
                lower_armed_next = 1'b0;
                raise_armed_next = 1'b0;
                lower_on_next    = 1'b0;
                raise_on_next    = 1'b0;
                lower_start_next = '0;
                raise_start_next = '0;
            end
        end
    end

    always_comb
    begin
        stat.raise_on = raise_on_next;
        stat.lower_on = lower_on_next;
        stat.moving   = is_frame && (lower_pat || raise_pat);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lower_armed_reg <= 1'b0;
            raise_armed_reg <= 1'b0;
            lower_on_reg    <= 1'b0;
            raise_on_reg    <= 1'b0;
            lower_start_reg <= '0;
            raise_start_reg <= '0;
        end
        else if (step)
        begin
            lower_armed_reg <= lower_armed_next;
            raise_armed_reg <= raise_armed_next;
            lower_on_reg    <= lower_on_next;
            raise_on_reg    <= raise_on_next;
            lower_start_reg <= lower_start_next;
            raise_start_reg <= raise_start_next;
        end
    end

endmodule : fpgrc_gesture

`default_nettype wire

@@ sv/fpgrc_checker.sv @@
// fpgrc_checker: port-level assertions for the gesture relay controller,
// bound to force_pad_gesture_relay_control. Depends on fpgrc_pkg.
`default_nettype none

module fpgrc_checker #(
    parameter int OUT_W = 56
) (
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             s_tvalid,
    input wire logic             s_tready,
    input wire logic             m_tvalid,
    input wire logic             m_tready,
    input wire logic [OUT_W-1:0] m_tdata,
    input wire logic             cfg_ready
);
    import fpgrc_pkg::*;

    logic [NUM_PADS-1:0] pads;
    logic                moving;

    assign moving = m_tdata[2];
    assign pads   = m_tdata[6:3];

    // held result must not change while stalled
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // moving is only reported with a raise or lower pattern
    a_moving_pat: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && moving |-> (pads == PAT_LOWER) || (pads == PAT_RAISE))
        else $error("motion_seen without gesture pattern");

    // accepted word reaches the output through the input and result registers when not stalled
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) ##1 m_tready |=> m_tvalid)
        else $error("result missing after accepted word");

    // result channel is empty when reset releases
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !m_tvalid)
        else $error("result valid out of reset");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("config channel not ready");

endmodule : fpgrc_checker

bind force_pad_gesture_relay_control fpgrc_checker #(
    .OUT_W (OUT_W)
) u_fpgrc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_ready (cfg_ready)
);

`default_nettype wire
